>>> rtl/core/gbba_pkg.sv
// Package for the grouped bitmap block allocator.
// Holds request kinds, status codes and config register indices; no dependencies.
package gbba_pkg;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_LOAD  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FREE  = 2'd1;
  localparam logic [1:0] ST_ALR_FREE = 2'd2;
  localparam logic [1:0] ST_BAD      = 2'd3;

  localparam logic [0:0] CFG_GROUPS = 1'b0;
  localparam logic [0:0] CFG_IPG    = 1'b1;

endpackage

>>> rtl/core/group_bitmap_block_allocator.sv
// Grouped bitmap first-fit allocator, top level.
// Depends on gbba_pkg.
// Flow: allocate reads and checks the bitmap a byte at a time; free first finds group and
// bit by shift-subtract division, then reads and writes the byte unless the number is
// rejected; load reads and writes one byte; every kind ends with a capacity sum over the groups in use.
// One transaction at a time; in_ready is low while a transaction is at work or a result
// waits, and rises in the cycle after the result is taken.
// Reset: synchronous, active low. A clearing pass of the bitmap memory runs
// after reset over all 1024 bytes, one byte a cycle, while no input is accepted.
module group_bitmap_block_allocator
  import gbba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [12:0] in_item_number,
  input  logic [9:0]  in_load_address,
  input  logic [7:0]  in_load_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [12:0] out_result_number,
  output logic [2:0]  out_result_group,
  output logic [10:0] out_group_free,
  output logic [13:0] out_total_free,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_wdata
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_RD    = 9'b000001000,
    S_CHK   = 9'b000010000,
    S_WR    = 9'b000100000,
    S_FIN   = 9'b001000000,
    S_OUT   = 9'b010000000,
    S_FCAP  = 9'b100000000
  } state_t;

  state_t state_r;

  // bitmap memory: group*128 + byte
  logic [7:0] mem [1024];
  logic [9:0] mem_addr;
  logic       mem_we;
  logic [7:0] mem_wdata;
  logic [7:0] mem_q_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_q_r <= mem[mem_addr];
  end

  logic [3:0]  groups_r;
  logic [10:0] ipg_r;
  logic [10:0] group_used_r [8];
  logic [13:0] total_used_r;

  logic [1:0]  kind_r;
  logic [12:0] num_r;
  logic [7:0]  data_r;
  logic [9:0]  addr_r;     // clear counter and byte pointer
  logic [2:0]  grp_r;
  logic [6:0]  byte_r;     // byte within group during scan
  logic [12:0] rem_r;      // division remainder
  logic [12:0] quo_r;
  logic [3:0]  step_r;
  logic [1:0]  status_r;
  logic [12:0] number_r;
  logic [2:0]  rgrp_r;
  logic [13:0] cap_r;      // capacity accumulator
  logic [3:0]  capn_r;

  // effective registers
  logic [10:0] ipg_eff;
  logic [3:0]  ng_eff;
  always_comb begin
    ipg_eff = (ipg_r > 11'd1024) ? 11'd1024 : ((ipg_r == 11'd0) ? 11'd1 : ipg_r);
    ng_eff  = (groups_r > 4'd8) ? 4'd8 : groups_r;
  end

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] c;
    c = '0;
    for (int k = 0; k < 8; k++) c = c + {3'd0, v[k]};
    return c;
  endfunction

  // lowest clear bit in the byte, limited to bits below ipg
  logic [7:0]  avail;
  logic [2:0]  fbit;
  logic        ffound;
  logic [10:0] bitbase;
  always_comb begin
    bitbase = {1'b0, byte_r, 3'd0};
    avail = ~mem_q_r;
    for (int k = 0; k < 8; k++)
      if ((bitbase + 11'(k)) >= ipg_eff) avail[k] = 1'b0;
    fbit = '0;
    ffound = 1'b0;
    for (int k = 7; k >= 0; k--)
      if (avail[k]) begin
        fbit = 3'(k);
        ffound = 1'b1;
      end
  end

  // trial subtract for the division step
  logic [13:0] shifted;
  assign shifted = {rem_r, num_r[12]};
  logic [13:0] diff;
  assign diff = shifted - {3'd0, ipg_eff};

  logic [7:0] clr_mask;
  always_comb begin
    clr_mask = 8'd0;
    clr_mask[rem_r[2:0]] = 1'b1;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_addr = addr_r;
    mem_wdata = 8'd0;
    case (state_r)
      S_CLEAR: mem_we = 1'b1;
      S_WR: begin
        mem_we = 1'b1;
        if (kind_r == KIND_LOAD) mem_wdata = data_r;
        else if (kind_r == KIND_FREE) mem_wdata = mem_q_r & ~clr_mask;
        else begin
          mem_wdata = mem_q_r;
          mem_wdata[fbit] = 1'b1;
        end
      end
      default: ;
    endcase
  end

  logic [10:0] gu_sel;
  assign gu_sel = group_used_r[rgrp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      addr_r <= '0;
      groups_r <= 4'd8;
      ipg_r <= 11'd1024;
      total_used_r <= '0;
      for (int g = 0; g < 8; g++) group_used_r[g] <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_GROUPS) groups_r <= cfg_wdata[3:0];
        else ipg_r <= cfg_wdata;
      end
      case (state_r)
        S_CLEAR: begin
          addr_r <= addr_r + 10'd1;
          if (addr_r == 10'd1023) state_r <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          kind_r <= in_kind;
          num_r <= in_item_number;
          data_r <= in_load_data;
          status_r <= ST_BAD;
          number_r <= '0;
          rgrp_r <= '0;
          grp_r <= '0;
          byte_r <= '0;
          rem_r <= '0;
          quo_r <= '0;
          step_r <= '0;
          case (in_kind)
            KIND_ALLOC: begin
              addr_r <= '0;
              status_r <= ST_NO_FREE;
              state_r <= (ng_eff == 4'd0) ? S_FIN : S_RD;
            end
            KIND_FREE: state_r <= S_DIV;
            KIND_LOAD: begin
              addr_r <= in_load_address;
              state_r <= S_RD;
            end
            default: state_r <= S_FIN;
          endcase
        end
        // restoring division, one quotient bit a cycle
        S_DIV: begin
          num_r <= {num_r[11:0], 1'b0};
          if (!diff[13]) begin
            rem_r <= diff[12:0];
            quo_r <= {quo_r[11:0], 1'b1};
          end else begin
            rem_r <= shifted[12:0];
            quo_r <= {quo_r[11:0], 1'b0};
          end
          step_r <= step_r + 4'd1;
          if (step_r == 4'd12) state_r <= S_CHK;
        end
        S_CHK: begin
          // free: check number and group, then read the byte
          if ((quo_r >= {9'd0, ng_eff}) || ({num_r} == 13'd0 && quo_r == 13'd0
              && rem_r == 13'd0)) begin
            state_r <= S_FIN;
          end else begin
            grp_r <= quo_r[2:0];
            rgrp_r <= quo_r[2:0];
            addr_r <= {quo_r[2:0], rem_r[9:3]};
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_WR;
        S_WR: begin
          state_r <= S_FIN;
          if (kind_r == KIND_LOAD) begin
            group_used_r[addr_r[9:7]] <= group_used_r[addr_r[9:7]]
              - {7'd0, pop8(mem_q_r)} + {7'd0, pop8(data_r)};
            total_used_r <= total_used_r - {10'd0, pop8(mem_q_r)}
              + {10'd0, pop8(data_r)};
            rgrp_r <= addr_r[9:7];
            status_r <= ST_OK;
          end else if (kind_r == KIND_FREE) begin
            if (!mem_q_r[rem_r[2:0]]) status_r <= ST_ALR_FREE;
            else begin
              status_r <= ST_OK;
              group_used_r[grp_r] <= group_used_r[grp_r] - 11'd1;
              total_used_r <= total_used_r - 14'd1;
            end
          end else if (ffound) begin
            status_r <= ST_OK;
            rgrp_r <= grp_r;
            number_r <= 13'(quo_r + {2'd0, bitbase} + {10'd0, fbit});
            group_used_r[grp_r] <= group_used_r[grp_r] + 11'd1;
            total_used_r <= total_used_r + 14'd1;
          end else begin
            // advance to next byte or group; quo_r holds group base number
            if ({1'b0, byte_r, 3'd0} + 11'd8 >= ipg_eff) begin
              if ({1'b0, grp_r} + 4'd1 >= ng_eff) state_r <= S_FIN;
              else begin
                grp_r <= grp_r + 3'd1;
                byte_r <= '0;
                quo_r <= quo_r + {2'd0, ipg_eff};
                addr_r <= {grp_r + 3'd1, 7'd0};
                state_r <= S_RD;
              end
            end else begin
              byte_r <= byte_r + 7'd1;
              addr_r <= addr_r + 10'd1;
              state_r <= S_RD;
            end
          end
        end
        S_FIN: begin
          cap_r <= '0;
          capn_r <= '0;
          state_r <= S_FCAP;
        end
        // capacity by repeated addition
        S_FCAP: begin
          if (capn_r == ng_eff) begin
            out_valid <= 1'b1;
            state_r <= S_OUT;
          end else begin
            cap_r <= cap_r + {3'd0, ipg_eff};
            capn_r <= capn_r + 4'd1;
          end
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_status = status_r;
  assign out_result_number = number_r;
  assign out_result_group = rgrp_r;
  assign out_group_free = (ipg_eff > gu_sel) ? ipg_eff - gu_sel : 11'd0;
  assign out_total_free = (cap_r > total_used_r) ? cap_r - total_used_r : 14'd0;

  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT) else $error("result shown outside output state");
  a_no_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready while result waits");
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped before taken");

endmodule

>>> verif/tb_group_bitmap_block_allocator.sv
// Self-checking testbench for the grouped bitmap first-fit allocator.
// Depends on gbba_pkg and group_bitmap_block_allocator; mirrors the bitmap and counts
// in its own predictor and checks every response in order.
module tb_group_bitmap_block_allocator
  import gbba_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GROUPS_MAX   = 8;
  localparam int IPG_MAX      = 1024;
  localparam int GROUP_BYTES  = IPG_MAX / 8;
  localparam int BITMAP_BYTES = GROUPS_MAX * GROUP_BYTES;
  localparam int CYCLE_LIMIT  = 20000000;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] number;
    logic [9:0]  addr;
    logic [7:0]  data;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [12:0] number;
    logic [2:0]  group;
    logic [10:0] group_free;
    logic [13:0] total_free;
  } response_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = '0;
  logic [12:0] in_item_number = '0;
  logic [9:0]  in_load_address = '0;
  logic [7:0]  in_load_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [12:0] out_result_number;
  logic [2:0]  out_result_group;
  logic [10:0] out_group_free;
  logic [13:0] out_total_free;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [10:0] cfg_wdata = '0;

  group_bitmap_block_allocator dut (.*);

  // Mirror of the allocator state
  logic [7:0]  bitmap_mirror [BITMAP_BYTES];
  int unsigned used_per_group [GROUPS_MAX];
  int unsigned used_total;
  int unsigned groups_reg = 8;
  int unsigned ipg_reg = 1024;

  request_t    pending_requests [$];
  response_t   awaited_responses [$];
  int          error_count = 0;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  logic        hold_request = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;
  int          cycle_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned live_ipg();
    if (ipg_reg > IPG_MAX) return IPG_MAX;
    if (ipg_reg == 0) return 1;
    return ipg_reg;
  endfunction

  function automatic int unsigned live_groups();
    return (groups_reg > GROUPS_MAX) ? GROUPS_MAX : groups_reg;
  endfunction

  // Apply one request to the mirror and return the response it must produce
  function automatic response_t serve_request(request_t r);
    response_t   rsp;
    int unsigned ipg, ng, g, i, n, a, old_pop, new_pop, cap;
    logic        found;
    ipg = live_ipg();
    ng = live_groups();
    rsp = '0;
    rsp.status = ST_BAD;
    found = 1'b0;
    case (r.kind)
      KIND_ALLOC: begin
        rsp.status = ST_NO_FREE;
        for (g = 0; g < ng && !found; g++) begin
          for (i = 0; i < ipg && !found; i++) begin
            if (!bitmap_mirror[g * GROUP_BYTES + i / 8][i % 8]) begin
              bitmap_mirror[g * GROUP_BYTES + i / 8][i % 8] = 1'b1;
              used_per_group[g]++;
              used_total++;
              rsp.status = ST_OK;
              rsp.number = 13'(g * ipg + i);
              rsp.group = 3'(g);
              found = 1'b1;
            end
          end
        end
      end
      KIND_FREE: begin
        n = r.number;
        g = n / ipg;
        i = n % ipg;
        if (n != 0 && g < ng) begin
          rsp.group = 3'(g);
          if (!bitmap_mirror[g * GROUP_BYTES + i / 8][i % 8]) begin
            rsp.status = ST_ALR_FREE;
          end else begin
            bitmap_mirror[g * GROUP_BYTES + i / 8][i % 8] = 1'b0;
            used_per_group[g]--;
            used_total--;
            rsp.status = ST_OK;
          end
        end
      end
      KIND_LOAD: begin
        a = r.addr;
        if (a < BITMAP_BYTES) begin
          g = a / GROUP_BYTES;
          old_pop = $countones(bitmap_mirror[a]);
          new_pop = $countones(r.data);
          bitmap_mirror[a] = r.data;
          used_per_group[g] = used_per_group[g] - old_pop + new_pop;
          used_total = used_total - old_pop + new_pop;
          rsp.group = 3'(g);
          rsp.status = ST_OK;
        end
      end
      default: ;
    endcase
    rsp.group_free = (ipg > used_per_group[rsp.group]) ?
                     11'(ipg - used_per_group[rsp.group]) : '0;
    cap = ng * ipg;
    rsp.total_free = (cap > used_total) ? 14'(cap - used_total) : '0;
    return rsp;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Driver: predict on each accepted transaction, then offer the next one
  always @(posedge clk) begin
    request_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_responses.push_back(serve_request({in_kind, in_item_number,
                                                   in_load_address, in_load_data}));
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_kind <= nxt.kind;
          in_item_number <= nxt.number;
          in_load_address <= nxt.addr;
          in_load_data <= nxt.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure, including one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Monitor: compare each accepted response with the oldest prediction
  always @(posedge clk) begin
    response_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_responses.size() == 0) begin
        report_mismatch("unexpected response, status", out_status, -1);
      end else begin
        want = awaited_responses.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_result_number !== want.number)
          report_mismatch("result_number", out_result_number, want.number);
        if (out_result_group !== want.group)
          report_mismatch("result_group", out_result_group, want.group);
        if (out_group_free !== want.group_free)
          report_mismatch("group_free", out_group_free, want.group_free);
        if (out_total_free !== want.total_free)
          report_mismatch("total_free", out_total_free, want.total_free);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_group_bitmap_block_allocator: errors");
      $finish;
    end
  end

  task automatic queue_request(input logic [1:0] k, input int unsigned num,
                               input int unsigned addr, input int unsigned data);
    request_t r;
    r.kind = k;
    r.number = 13'(num);
    r.addr = 10'(addr);
    r.data = 8'(data);
    pending_requests.push_back(r);
  endtask

  // Hold until every queued transaction has been answered, then let the block settle
  task automatic drain();
    while (pending_requests.size() > 0 || in_valid || awaited_responses.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 11'(val);
    if (idx == CFG_GROUPS) groups_reg = val & 4'hF;
    else ipg_reg = val & 11'h7FF;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly allocate/free traffic near the allocated region, with loads and noise
  task automatic queue_random(input int count);
    int unsigned ipg, ng, cap, sel, issued, top, grp;
    ipg = live_ipg();
    ng = live_groups();
    cap = (ng == 0) ? ipg : ng * ipg;
    issued = 0;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        queue_request(KIND_ALLOC, $urandom, $urandom, $urandom);
        issued++;
      end else if (sel < 80) begin
        top = (issued + 2 < cap) ? issued + 2 : cap;
        queue_request(KIND_FREE, $urandom_range(top), $urandom, $urandom);
      end else if (sel < 88) begin
        queue_request(KIND_FREE, $urandom_range(8191), $urandom, $urandom);
      end else if (sel < 95) begin
        grp = $urandom_range(GROUPS_MAX - 1);
        queue_request(KIND_LOAD, $urandom, grp * GROUP_BYTES + $urandom_range((ipg + 7) / 8),
                      $urandom_range(255));
      end else if (sel < 98) begin
        queue_request(KIND_LOAD, $urandom, $urandom_range(1023), $urandom_range(255));
      end else begin
        queue_request(2'd3, $urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic run_phase(input int unsigned groups, input int unsigned ipg,
                           input int count, input int mode);
    drain();
    write_reg(CFG_GROUPS, groups);
    write_reg(CFG_IPG, ipg);
    case (mode % 4)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 60; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 60; end
      default: begin sender_idle_pct = 26; receiver_stall_pct = 26; end
    endcase
    queue_random(count);
  endtask

  initial begin
    for (int b = 0; b < BITMAP_BYTES; b++) bitmap_mirror[b] = '0;
    for (int g = 0; g < GROUPS_MAX; g++) used_per_group[g] = 0;
    used_total = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset configuration, every kind and the error paths
    queue_request(KIND_ALLOC, 0, 0, 0);
    queue_request(KIND_ALLOC, 0, 0, 0);
    queue_request(KIND_ALLOC, 8191, 1023, 255);
    queue_request(KIND_FREE, 0, 0, 0);          // item zero is never valid
    queue_request(KIND_FREE, 1, 0, 0);
    queue_request(KIND_FREE, 1, 0, 0);          // freeing twice
    queue_request(KIND_FREE, 8191, 0, 0);
    queue_request(KIND_LOAD, 0, 0, 8'hFF);
    queue_request(KIND_LOAD, 0, 1023, 8'hAA);   // last byte of the last group
    queue_request(KIND_FREE, 8191, 0, 0);
    queue_request(KIND_LOAD, 0, 0, 8'h00);
    queue_request(2'd3, 8191, 1023, 255);       // unknown kind
    queue_request(KIND_ALLOC, 0, 0, 0);
    drain();
    // No group in use: allocate finds nothing, every free is rejected
    write_reg(CFG_GROUPS, 0);
    queue_request(KIND_ALLOC, 0, 0, 0);
    queue_request(KIND_FREE, 5, 0, 0);
    queue_request(KIND_LOAD, 0, 300, 8'h0F);
    drain();
    // Saturating registers, and a zero item count that acts as one
    write_reg(CFG_GROUPS, 15);
    write_reg(CFG_IPG, 2047);
    queue_request(KIND_ALLOC, 0, 0, 0);
    queue_request(KIND_FREE, 2, 0, 0);
    drain();
    write_reg(CFG_IPG, 0);
    queue_request(KIND_ALLOC, 0, 0, 0);
    queue_request(KIND_FREE, 7, 0, 0);
    queue_request(KIND_LOAD, 0, 1, 8'h80);      // bits above the item count

    run_phase(1, 8, 100, 0);
    run_phase(2, 16, 100, 1);
    run_phase(8, 8, 110, 2);
    // Long hold-off on the receiver while the sender keeps offering
    run_phase(3, 24, 100, 0);
    hold_request <= 1'b1;
    run_phase(15, 0, 100, 3);
    run_phase(4, 100, 100, 1);
    run_phase(0, 40, 30, 2);
    run_phase(8, 1024, 110, 3);
    run_phase(1, 2047, 100, 0);

    drain();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_group_bitmap_block_allocator: clean");
    end else begin
      $display("tb_group_bitmap_block_allocator: errors");
    end
    $finish;
  end

endmodule

>>> group_bitmap_block_allocator.f
rtl/core/gbba_pkg.sv
rtl/core/group_bitmap_block_allocator.sv
verif/tb_group_bitmap_block_allocator.sv
